// ===== src/lrpw_pkg.sv =====
// shared constants, register map and types for the line raster pixel writer
package lrpw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_BITS       = 12;
  localparam int ADDR_BITS      = 32;
  localparam int PIXEL_BITS     = 8;
  localparam int OP_BITS        = 2;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  // item opcodes carried on tuser
  localparam logic [OP_BITS-1:0] OP_STEP = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LINE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FILL = 2'd2;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_FRAME_BASE    = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [DIM_BITS-1:0] WIDTH_RST  = 12'd480;
  localparam logic [DIM_BITS-1:0] HEIGHT_RST = 12'd272;

  typedef struct packed {
    logic [ADDR_BITS-1:0] frame_base;
    logic [DIM_BITS-1:0]  screen_width;
    logic [DIM_BITS-1:0]  screen_height;
  } lrpw_cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } lrpw_emit_t;

endpackage

// ===== src/lrpw_cfg_regs.sv =====
// register file behind the configuration port
module lrpw_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrpw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lrpw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lrpw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output lrpw_pkg::lrpw_cfg_t                 cfg
);

  logic [lrpw_pkg::ADDR_BITS-1:0] base_r;
  logic [lrpw_pkg::DIM_BITS-1:0]  width_r;
  logic [lrpw_pkg::DIM_BITS-1:0]  height_r;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      width_r  <= lrpw_pkg::WIDTH_RST;
      height_r <= lrpw_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lrpw_pkg::REG_FRAME_BASE:    base_r   <= pwdata;
        lrpw_pkg::REG_SCREEN_WIDTH:  width_r  <= pwdata[lrpw_pkg::DIM_BITS-1:0];
        lrpw_pkg::REG_SCREEN_HEIGHT: height_r <= pwdata[lrpw_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrpw_pkg::REG_FRAME_BASE:    prdata = base_r;
      lrpw_pkg::REG_SCREEN_WIDTH:  prdata = lrpw_pkg::CFG_DATA_W'(width_r);
      lrpw_pkg::REG_SCREEN_HEIGHT: prdata = lrpw_pkg::CFG_DATA_W'(height_r);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.frame_base    = base_r;
  assign cfg.screen_width  = width_r;
  assign cfg.screen_height = height_r;

endmodule

// ===== src/lrpw_core.sv =====
// walker state: bresenham line stepper and raster fill counter
module lrpw_core #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic [lrpw_pkg::OP_BITS-1:0]      op,
  input  logic [COORD_BITS-1:0]             start_x,
  input  logic [COORD_BITS-1:0]             start_y,
  input  logic [COORD_BITS-1:0]             end_x,
  input  logic [COORD_BITS-1:0]             end_y,
  input  logic [lrpw_pkg::PIXEL_BITS-1:0]   paint,
  input  logic [lrpw_pkg::DIM_BITS-1:0]     scr_width,
  input  logic [lrpw_pkg::DIM_BITS-1:0]     scr_height,
  output lrpw_pkg::lrpw_emit_t              emit,
  output logic [COORD_BITS:0]               col_ext,
  output logic [COORD_BITS:0]               row_ext,
  output logic [lrpw_pkg::PIXEL_BITS-1:0]   colour
);

  localparam int W  = COORD_BITS;
  localparam int M  = COORD_BITS + 1;
  localparam int E  = COORD_BITS + 2;
  localparam int FW = ((W > lrpw_pkg::DIM_BITS) ? W : lrpw_pkg::DIM_BITS) + 1;

  logic                               busy_r, busy_nxt;
  logic                               fill_r, fill_nxt;
  logic [W-1:0]                       col_r, col_nxt;
  logic [W-1:0]                       row_r, row_nxt;
  logic [M-1:0]                       rem_r, rem_nxt;
  logic signed [E-1:0]                err_r, err_nxt;
  logic [M-1:0]                       adx_r, adx_nxt;
  logic [M-1:0]                       ady_r, ady_nxt;
  logic [2:0]                         oct_r, oct_nxt;
  logic [lrpw_pkg::PIXEL_BITS-1:0]    colour_r, colour_nxt;

  // line setup
  logic signed [M-1:0]  dx, dy;
  logic [M-1:0]         adx_s, ady_s, major_s, minor_s;
  logic                 ymaj_s;
  logic [2:0]           oct_s;
  logic signed [E-1:0]  err_s;

  // shared advance unit
  logic                 is_line;
  logic [W-1:0]         adv_col_in, adv_row_in;
  logic signed [E-1:0]  adv_err_in;
  logic [M-1:0]         adv_adx_in, adv_ady_in;
  logic [2:0]           adv_oct_in;
  logic [2*W+E-1:0]     adv_out;

  // fill walk
  logic [W-1:0]         fcol, frow;
  logic                 row_end, fill_last;

  logic [M-1:0]         rem_dec;
  logic                 emit_sgn;
  logic [W-1:0]         emit_col, emit_row;

  function automatic logic [2*W+E-1:0] advance(
    input logic [W-1:0]        col,
    input logic [W-1:0]        row,
    input logic signed [E-1:0] err,
    input logic [M-1:0]        ax,
    input logic [M-1:0]        ay,
    input logic [2:0]          oct
  );
    logic                ymaj;
    logic [M-1:0]        major, minor;
    logic [W-1:0]        xs, ys, c, r;
    logic signed [E-1:0] e;
    ymaj  = oct[2];
    major = ymaj ? ay : ax;
    minor = ymaj ? ax : ay;
    xs    = oct[0] ? {W{1'b1}} : W'(1);
    ys    = oct[1] ? {W{1'b1}} : W'(1);
    c     = col;
    r     = row;
    e     = err;
    // minor axis step when the error is positive
    if (e > 0) begin
      if (ymaj) c = c + xs;
      else      r = r + ys;
      e = e - $signed({1'b0, major});
    end
    if (ymaj) r = r + ys;
    else      c = c + xs;
    e = e + $signed({1'b0, minor});
    return {c, r, e};
  endfunction

  always_comb begin
    dx      = $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
    dy      = $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
    adx_s   = dx[M-1] ? M'(-dx) : M'(dx);
    ady_s   = dy[M-1] ? M'(-dy) : M'(dy);
    ymaj_s  = ady_s > adx_s;
    major_s = ymaj_s ? ady_s : adx_s;
    minor_s = ymaj_s ? adx_s : ady_s;
    oct_s   = {ymaj_s, dy[M-1], dx[M-1]};
    err_s   = $signed({1'b0, minor_s}) - $signed({2'b00, major_s[M-1:1]});
  end

  assign is_line    = (op == lrpw_pkg::OP_LINE);
  assign adv_col_in = is_line ? start_x : col_r;
  assign adv_row_in = is_line ? start_y : row_r;
  assign adv_err_in = is_line ? err_s   : err_r;
  assign adv_adx_in = is_line ? adx_s   : adx_r;
  assign adv_ady_in = is_line ? ady_s   : ady_r;
  assign adv_oct_in = is_line ? oct_s   : oct_r;
  assign adv_out    = advance(adv_col_in, adv_row_in, adv_err_in,
                              adv_adx_in, adv_ady_in, adv_oct_in);

  assign fcol      = (op == lrpw_pkg::OP_FILL) ? '0 : col_r;
  assign frow      = (op == lrpw_pkg::OP_FILL) ? '0 : row_r;
  assign row_end   = (FW'(fcol) + FW'(1)) >= FW'(scr_width);
  assign fill_last = row_end && ((FW'(frow) + FW'(1)) >= FW'(scr_height));
  assign rem_dec   = rem_r - M'(1);

  always_comb begin
    busy_nxt   = busy_r;
    fill_nxt   = fill_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rem_nxt    = rem_r;
    err_nxt    = err_r;
    adx_nxt    = adx_r;
    ady_nxt    = ady_r;
    oct_nxt    = oct_r;
    colour_nxt = colour_r;
    emit.valid = 1'b0;
    emit.last  = 1'b0;
    emit_sgn   = 1'b0;
    emit_col   = fcol;
    emit_row   = frow;
    case (op)
      lrpw_pkg::OP_LINE: begin
        colour_nxt = paint;
        fill_nxt   = 1'b0;
        oct_nxt    = oct_s;
        adx_nxt    = adx_s;
        ady_nxt    = ady_s;
        rem_nxt    = major_s;
        emit.valid = 1'b1;
        emit.last  = (major_s == '0);
        emit_sgn   = 1'b1;
        emit_col   = start_x;
        emit_row   = start_y;
        busy_nxt   = (major_s != '0);
        if (major_s != '0) begin
          {col_nxt, row_nxt, err_nxt} = adv_out;
        end else begin
          col_nxt = start_x;
          row_nxt = start_y;
          err_nxt = err_s;
        end
      end
      lrpw_pkg::OP_FILL, lrpw_pkg::OP_STEP: begin
        if (op == lrpw_pkg::OP_FILL) begin
          colour_nxt = paint;
          fill_nxt   = 1'b1;
          col_nxt    = '0;
          row_nxt    = '0;
          busy_nxt   = (scr_width != '0) && (scr_height != '0);
        end
        if ((op == lrpw_pkg::OP_FILL) ? busy_nxt : (busy_r && fill_r)) begin
          // raster walk, registers read live
          emit.valid = 1'b1;
          emit.last  = fill_last;
          if (fill_last) begin
            busy_nxt = 1'b0;
          end else if (row_end) begin
            col_nxt = '0;
            row_nxt = frow + W'(1);
          end else begin
            col_nxt = fcol + W'(1);
          end
        end else if (op == lrpw_pkg::OP_STEP && busy_r) begin
          rem_nxt    = rem_dec;
          emit.valid = 1'b1;
          emit.last  = (rem_dec == '0);
          emit_sgn   = 1'b1;
          emit_col   = col_r;
          emit_row   = row_r;
          if (rem_dec == '0) begin
            busy_nxt = 1'b0;
          end else begin
            {col_nxt, row_nxt, err_nxt} = adv_out;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      fill_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      rem_r    <= '0;
      err_r    <= '0;
      adx_r    <= '0;
      ady_r    <= '0;
      oct_r    <= '0;
      colour_r <= '0;
    end else if (go) begin
      busy_r   <= busy_nxt;
      fill_r   <= fill_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rem_r    <= rem_nxt;
      err_r    <= err_nxt;
      adx_r    <= adx_nxt;
      ady_r    <= ady_nxt;
      oct_r    <= oct_nxt;
      colour_r <= colour_nxt;
    end
  end

  assign col_ext = {emit_sgn & emit_col[W-1], emit_col};
  assign row_ext = {emit_sgn & emit_row[W-1], emit_row};
  assign colour  = colour_nxt;

endmodule

// ===== src/lrpw_addr.sv =====
// pixel byte address: base + row * stride + column, modulo 2^32
module lrpw_addr #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input  logic [lrpw_pkg::ADDR_BITS-1:0]  frame_base,
  input  logic [lrpw_pkg::DIM_BITS-1:0]   scr_width,
  input  logic [COORD_BITS:0]             col_ext,
  input  logic [COORD_BITS:0]             row_ext,
  output logic [lrpw_pkg::ADDR_BITS-1:0]  pixel_address
);

  localparam int P = COORD_BITS + 1 + lrpw_pkg::DIM_BITS + 1;

  logic signed [P-1:0] row_off;

  assign row_off = $signed(row_ext) * $signed({1'b0, scr_width});

  assign pixel_address = frame_base
                       + lrpw_pkg::ADDR_BITS'(row_off)
                       + lrpw_pkg::ADDR_BITS'($signed(col_ext));

endmodule

// ===== src/line_raster_pixel_writer.sv =====
// top level of the line raster pixel writer: item register, walker, address, result register
//
//  channel | dir | handshake                 | payload
//  in_     | in  | in_tvalid / in_tready     | tuser op, tdata endpoints and paint
//  out_    | out | out_tvalid / out_tready   | tdata address and colour, tlast last
//  cfg_    | in  | apb psel/penable, pready  | frame_base, screen_width, screen_height
//
// one item per cycle sustained while out_tready drains the result register; an item
// waits in the item register, then loads into the result register, which offers it
// the walker state updates as each item moves on, one multiplier feeds the address add
// reset is synchronous active low, clears the walker and both valid flags and loads the
// register defaults
// a stalled result holds in the result register; the item register fills behind it and
// in_tready drops only when both stages are full
module line_raster_pixel_writer #(
  parameter int COORD_BITS = lrpw_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x, start_y, end_x, end_y, paint
  input  logic [((4 * COORD_BITS + lrpw_pkg::PIXEL_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic [lrpw_pkg::OP_BITS-1:0]        in_tuser,   // op
  // pixel write stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_address, pixel_value
  output logic [lrpw_pkg::ADDR_BITS + lrpw_pkg::PIXEL_BITS - 1:0] out_tdata,
  output logic                                out_tlast,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lrpw_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [lrpw_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [lrpw_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int W          = COORD_BITS;

  lrpw_pkg::lrpw_cfg_t                  cfg;
  lrpw_pkg::lrpw_emit_t                 emit;

  // item register
  logic                                 s1_valid_r;
  logic [lrpw_pkg::OP_BITS-1:0]         s1_op_r;
  logic [W-1:0]                         s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  logic [lrpw_pkg::PIXEL_BITS-1:0]      s1_paint_r;
  logic                                 s1_go;
  logic                                 out_free;
  logic                                 in_acc;

  // result register
  logic                                 out_valid_r;
  logic [lrpw_pkg::ADDR_BITS-1:0]       out_addr_r;
  logic [lrpw_pkg::PIXEL_BITS-1:0]      out_pix_r;
  logic                                 out_last_r;

  logic [W:0]                           col_ext, row_ext;
  logic [lrpw_pkg::PIXEL_BITS-1:0]      colour;
  logic [lrpw_pkg::ADDR_BITS-1:0]       pix_addr;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_tuser;
      s1_sx_r    <= in_tdata[W-1:0];
      s1_sy_r    <= in_tdata[2*W-1:W];
      s1_ex_r    <= in_tdata[3*W-1:2*W];
      s1_ey_r    <= in_tdata[4*W-1:3*W];
      s1_paint_r <= in_tdata[4*W +: lrpw_pkg::PIXEL_BITS];
    end
  end

  lrpw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lrpw_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .op         (s1_op_r),
    .start_x    (s1_sx_r),
    .start_y    (s1_sy_r),
    .end_x      (s1_ex_r),
    .end_y      (s1_ey_r),
    .paint      (s1_paint_r),
    .scr_width  (cfg.screen_width),
    .scr_height (cfg.screen_height),
    .emit       (emit),
    .col_ext    (col_ext),
    .row_ext    (row_ext),
    .colour     (colour)
  );

  lrpw_addr #(.COORD_BITS(COORD_BITS)) u_addr (
    .frame_base    (cfg.frame_base),
    .scr_width     (cfg.screen_width),
    .col_ext       (col_ext),
    .row_ext       (row_ext),
    .pixel_address (pix_addr)
  );

  // result register: reload when the item moves, else drain on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= emit.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_addr_r <= pix_addr;
      out_pix_r  <= colour;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r, out_addr_r};
  assign out_tlast  = out_last_r;

endmodule
